[rtl/note_waveform_oscillator_mixer_core_assert.svh]
// Assertion macros used by the note oscillator mixer port checker.
`ifndef NOTE_WAVEFORM_OSCILLATOR_MIXER_CORE_ASSERT_SVH
`define NOTE_WAVEFORM_OSCILLATOR_MIXER_CORE_ASSERT_SVH

// Same-cycle implication, inactive while reset is high.
`define NWOM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, inactive while reset is high.
`define NWOM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define NWOM_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nwom_pkg.sv]
// Package with types, constants and constant tables of the note oscillator mixer.
`timescale 1ns / 1ps
package nwom_pkg;

  localparam int AUDIO_RATE_HZ   = 44100;
  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;

  localparam int NOTE_W  = 7;
  localparam int VEL_W   = 7;
  localparam int INST_W  = 7;
  localparam int GAIN_W  = 16;
  localparam int MIX_W   = 16;
  localparam int WMAG_W  = 15;
  localparam int GAIN_FRAC = 14;

  localparam int NOTE_COUNT = 1 << NOTE_W;
  localparam int SINE_Q     = 1 << (SINE_TABLE_BITS - 2);

  // Serial multiplier and divider widths.
  localparam int K_W     = VEL_W + GAIN_W;
  localparam int MPLR_W  = 16;
  localparam int M2_W    = K_W + MPLR_W - GAIN_FRAC;
  localparam int Q_W     = 16;
  localparam int REM_W   = 7;
  localparam int CNT_W   = 3;
  localparam int MUL1_DIGITS = (VEL_W + 1) / 2;

  localparam logic [CNT_W-1:0] MUL1_LAST = CNT_W'(MUL1_DIGITS - 1);
  localparam logic [CNT_W-1:0] MUL2_LAST = CNT_W'(MPLR_W / 2 - 1);
  localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(Q_W / 2 - 1);

  localparam logic [REM_W+1:0] DIV_1 = (REM_W+2)'(127);
  localparam logic [REM_W+1:0] DIV_2 = (REM_W+2)'(254);
  localparam logic [REM_W+1:0] DIV_3 = (REM_W+2)'(381);

  localparam logic [M2_W-1:0] SAT_POS = M2_W'(127 * 32768);
  localparam logic [M2_W-1:0] SAT_NEG = M2_W'(127 * 32769);

  localparam logic [MIX_W:0]   NOTE_MAX = 17'h07FFF;
  localparam logic [MIX_W:0]   NOTE_MIN = 17'h18000;
  localparam logic [MIX_W-1:0] MIX_MAX  = 16'h7FFF;
  localparam logic [MIX_W-1:0] MIX_MIN  = 16'h8000;
  localparam logic [WMAG_W-1:0] WAVE_FULL = '1;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SQUARE = 2'd1;
  localparam logic [1:0] WAVE_SAW    = 2'd2;
  localparam logic [1:0] WAVE_TRI    = 2'd3;

  typedef struct packed {
    logic                     note_start;
    logic [NOTE_W-1:0]        note;
    logic [VEL_W-1:0]         velocity;
    logic [INST_W-1:0]        instrument;
    logic [GAIN_W-1:0]        gain;
    logic signed [MIX_W-1:0]  mix_in;
  } tick_t;

  typedef struct packed {
    logic signed [MIX_W-1:0] mix_out;
    logic                    clipped;
  } mix_t;

  typedef struct packed {
    logic              neg;
    logic [WMAG_W-1:0] mag;
  } wave_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] last;
  } mul_ctl_t;

  typedef struct packed {
    logic              done;
    logic [K_W-1:0]    hi;
    logic [MPLR_W-1:0] lo;
  } mul_res_t;

  typedef struct packed {
    logic           done;
    logic           sat;
    logic           neg;
    logic [Q_W-1:0] q;
  } div_res_t;

  typedef logic [PHASE_BITS-1:0] inc_tab_t [NOTE_COUNT];
  typedef logic [WMAG_W-1:0] sine_tab_t [SINE_Q];

  localparam logic [63:0] SEMI_HZ [12] = '{
    64'd17145893, 64'd18165441, 64'd19245614, 64'd20390018, 64'd21602472, 64'd22887021,
    64'd24247954, 64'd25689813, 64'd27217409, 64'd28835840, 64'd30550508, 64'd32367136
  };

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  function automatic inc_tab_t build_inc_tab();
    inc_tab_t    tab;
    logic [63:0] t;
    int          k;
    for (int n = 0; n < NOTE_COUNT; n++) begin
      t = (SEMI_HZ[n % 12] << 28) / 64'(AUDIO_RATE_HZ);
      k = 49 - PHASE_BITS - n / 12;
      tab[n] = PHASE_BITS'((t + (64'd1 << (k - 1))) >> k);
    end
    return tab;
  endfunction

  // Quarter-wave sine sample from a truncated Taylor series in Q30.
  function automatic logic [WMAG_W-1:0] quarter_sine(input logic [63:0] r);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] sum;
    x = (r * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
    x2 = (x * x) >> 30;
    term = x;
    sum = signed'(x);
    for (int i = 1; i <= 5; i++) begin
      term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    v = (64'(sum) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[WMAG_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine_tab();
    sine_tab_t tab;
    for (int i = 0; i < SINE_Q; i++) begin
      tab[i] = quarter_sine(64'(i));
    end
    return tab;
  endfunction

  localparam inc_tab_t  NOTE_INC  = build_inc_tab();
  localparam sine_tab_t SINE_TAB  = build_sine_tab();
  localparam logic [WMAG_W-1:0] SINE_PEAK = quarter_sine(64'(SINE_Q));

  function automatic logic [1:0] wave_kind(input logic [INST_W-1:0] inst);
    logic [1:0] kind;
    unique case (inst)
      7'd3, 7'd6, 7'd29, 7'd37, 7'd38, 7'd40: kind = WAVE_SQUARE;
      7'd28, 7'd33, 7'd39:                    kind = WAVE_SAW;
      7'd95, 7'd96, 7'd100:                   kind = WAVE_TRI;
      default:                                kind = WAVE_SINE;
    endcase
    return kind;
  endfunction

endpackage

[rtl/note_waveform_oscillator_mixer_core.sv]
// Top level of the note oscillator mixer: sequencing, mixing and output register.
//
// One input word on the tick channel (tick_valid, tick_ready, tick) is one
// output sample of a sounding note. For each accepted word the block returns
// one word on the mix channel (mix_valid, mix_ready, mix): the note sample
// added to the incoming mix sample, clipped to 16 bits, with a clip flag.
// An accepted word runs through a radix-4 serial multiplier twice (velocity
// times gain, then wave times that product) and a radix-4 serial divider by
// 127. The result passes the states MUL1, MUL2, DIV and OUT on its way to the
// output register, and a new word is accepted only once the block is back in
// idle. Only one word is in progress at a time.
// A finished word waits in the output register while the receiver stalls;
// the next tick is accepted meanwhile and is held at its end until the output
// register is free. Reset clears the phase accumulator to zero, empties the
// output register and returns the block to idle, ready for a word.
`timescale 1ns / 1ps
module note_waveform_oscillator_mixer_core import nwom_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  tick_valid,
  output logic  tick_ready,
  input  tick_t tick,
  output logic  mix_valid,
  input  logic  mix_ready,
  output mix_t  mix
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic              accept;
  logic              load_out;
  logic [MIX_W-1:0]  mix_in_q;
  wave_t             wave;
  mul_ctl_t          mctl;
  mul_res_t          mres;
  logic [K_W-1:0]    mcand;
  logic [MPLR_W-1:0] mplr;
  logic [K_W-1:0]    k_val;
  logic [M2_W-1:0]   m2;
  logic              div_start;
  div_res_t          dres;
  logic [MIX_W:0]    addend;
  logic              add_cin;
  logic [MIX_W+1:0]  total;
  logic              ovf;
  mix_t              result;

  assign tick_ready = (state == ST_IDLE);
  assign accept = tick_valid && tick_ready;
  assign load_out = (state == ST_OUT) && (!mix_valid || mix_ready);

  nwom_osc u_osc (
    .clk  (clk),
    .rst  (rst),
    .load (accept),
    .tick (tick),
    .wave (wave)
  );

  assign k_val = K_W'({mres.hi, mres.lo} >> (MPLR_W - 2 * MUL1_DIGITS));
  assign m2 = M2_W'({mres.hi, mres.lo} >> GAIN_FRAC);

  assign mctl.start = accept || ((state == ST_MUL1) && mres.done);
  assign mctl.last = accept ? MUL1_LAST : MUL2_LAST;
  assign mcand = accept ? K_W'(tick.gain) : k_val;
  assign mplr = accept ? MPLR_W'(tick.velocity) : {1'b0, wave.mag};

  nwom_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mctl),
    .mcand_in (mcand),
    .mplr_in  (mplr),
    .res      (mres)
  );

  assign div_start = (state == ST_MUL2) && mres.done;

  nwom_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .m2    (m2),
    .neg   (wave.neg),
    .res   (dres)
  );

  always_comb begin
    if (dres.sat) begin
      addend = dres.neg ? NOTE_MIN : NOTE_MAX;
    end else begin
      addend = dres.neg ? ~{1'b0, dres.q} : {1'b0, dres.q};
    end
    add_cin = !dres.sat && dres.neg;
    total = {{2{mix_in_q[MIX_W-1]}}, mix_in_q} + {addend[MIX_W], addend}
            + (MIX_W+2)'(add_cin);
    ovf = (total[MIX_W+1:MIX_W-1] != 3'b000) && (total[MIX_W+1:MIX_W-1] != 3'b111);
    result.mix_out = ovf ? (total[MIX_W+1] ? MIX_MIN : MIX_MAX) : total[MIX_W-1:0];
    result.clipped = ovf || dres.sat;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_MUL1;
      ST_MUL1: if (mres.done) state_next = ST_MUL2;
      ST_MUL2: if (mres.done) state_next = ST_DIV;
      ST_DIV:  if (dres.done) state_next = ST_OUT;
      ST_OUT:  if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mix_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        mix_valid <= 1'b1;
      end else if (mix_ready) begin
        mix_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mix_in_q <= tick.mix_in;
    end
    if (load_out) begin
      mix <= result;
    end
  end

endmodule

[rtl/nwom_osc.sv]
// Phase accumulator and waveform shaper giving the wave magnitude and sign.
`timescale 1ns / 1ps
module nwom_osc import nwom_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  tick_t tick,
  output wave_t wave
);

  logic [PHASE_BITS-1:0]        acc;
  logic [PHASE_BITS-1:0]        ph;
  logic [PHASE_BITS-1:0]        base;
  logic [1:0]                   kind;
  logic [SINE_TABLE_BITS-1:0]   idx;
  logic [SINE_TABLE_BITS-3:0]   r;
  logic [SINE_TABLE_BITS-3:0]   rc;
  logic [WMAG_W-1:0]            sine_mag;
  logic [PHASE_BITS-1:0]        ramp;
  logic                         ramp_c;
  logic [PHASE_BITS:0]          ramp_mag;
  logic [PHASE_BITS+WMAG_W:0]   ramp_scaled;
  wave_t                        wave_next;

  assign base = tick.note_start ? '0 : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (load) begin
      acc <= base + NOTE_INC[tick.note];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ph <= base;
      kind <= wave_kind(tick.instrument);
    end
    wave <= wave_next;
  end

  assign idx = ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign r = idx[SINE_TABLE_BITS-3:0];
  assign rc = '0 - r;
  assign sine_mag = idx[SINE_TABLE_BITS-2] ? ((r == '0) ? SINE_PEAK : SINE_TAB[rc])
                                           : SINE_TAB[r];

  always_comb begin
    if (kind == WAVE_SAW) begin
      ramp = {ph[PHASE_BITS-2:0], 1'b0};
      ramp_c = !ph[PHASE_BITS-1];
    end else begin
      ramp = {ph[PHASE_BITS-3:0], 2'b00};
      ramp_c = ph[PHASE_BITS-2];
    end
    ramp_mag = ramp_c ? ({1'b1, {PHASE_BITS{1'b0}}} - {1'b0, ramp}) : {1'b0, ramp};
    ramp_scaled = {ramp_mag, {WMAG_W{1'b0}}} - {{WMAG_W{1'b0}}, ramp_mag};
  end

  always_comb begin
    unique case (kind)
      WAVE_SQUARE: begin
        wave_next.mag = WAVE_FULL;
        wave_next.neg = ph[PHASE_BITS-1];
      end
      WAVE_SAW: begin
        wave_next.mag = ramp_scaled[PHASE_BITS+WMAG_W-1:PHASE_BITS];
        wave_next.neg = !ph[PHASE_BITS-1];
      end
      WAVE_TRI: begin
        wave_next.mag = ramp_scaled[PHASE_BITS+WMAG_W-1:PHASE_BITS];
        wave_next.neg = ph[PHASE_BITS-1];
      end
      default: begin
        wave_next.mag = sine_mag;
        wave_next.neg = idx[SINE_TABLE_BITS-1];
      end
    endcase
  end

endmodule

[rtl/nwom_mul.sv]
// Radix-4 digit-serial multiplier shared by the velocity and wave products.
`timescale 1ns / 1ps
module nwom_mul import nwom_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  mul_ctl_t          ctl,
  input  logic [K_W-1:0]    mcand_in,
  input  logic [MPLR_W-1:0] mplr_in,
  output mul_res_t          res
);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [K_W-1:0]    mcand;
  logic [K_W-1:0]    hi;
  logic [MPLR_W-1:0] lo;
  logic [K_W+1:0]    sum;

  assign sum = {2'b00, hi} + (lo[0] ? {2'b00, mcand} : '0) + (lo[1] ? {1'b0, mcand, 1'b0} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt <= ctl.last;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mcand <= mcand_in;
      hi <= '0;
      lo <= mplr_in;
    end else if (busy) begin
      hi <= sum[K_W+1:2];
      lo <= {sum[1:0], lo[MPLR_W-1:2]};
    end
  end

  assign res.done = done;
  assign res.hi = hi;
  assign res.lo = lo;

endmodule

[rtl/nwom_div.sv]
// Radix-4 serial divider by 127 with note sample saturation detect.
`timescale 1ns / 1ps
module nwom_div import nwom_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [M2_W-1:0] m2,
  input  logic            neg,
  output div_res_t        res
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [REM_W-1:0] rem;
  logic [Q_W-1:0]   dsr;
  logic             sat;
  logic             neg_q;
  logic [REM_W+1:0] t;
  logic [1:0]       digit;
  logic [REM_W+1:0] sub;

  assign t = {rem, dsr[Q_W-1:Q_W-2]};

  always_comb begin
    priority if (t >= DIV_3) begin
      digit = 2'd3;
      sub = DIV_3;
    end else if (t >= DIV_2) begin
      digit = 2'd2;
      sub = DIV_2;
    end else if (t >= DIV_1) begin
      digit = 2'd1;
      sub = DIV_1;
    end else begin
      digit = 2'd0;
      sub = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= DIV_LAST;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= REM_W'(m2 >> Q_W);
      dsr <= m2[Q_W-1:0];
      sat <= neg ? (m2 >= SAT_NEG) : (m2 >= SAT_POS);
      neg_q <= neg;
    end else if (busy) begin
      rem <= REM_W'(t - sub);
      dsr <= {dsr[Q_W-3:0], digit};
    end
  end

  assign res.done = done;
  assign res.sat = sat;
  assign res.neg = neg_q;
  assign res.q = dsr;

endmodule

[rtl/nwom_port_chk.sv]
// Port-level checker for the note oscillator mixer, bound to the top level.
`timescale 1ns / 1ps
`include "note_waveform_oscillator_mixer_core_assert.svh"
module nwom_port_chk import nwom_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  tick_valid,
  input logic  tick_ready,
  input tick_t tick,
  input logic  mix_valid,
  input logic  mix_ready,
  input mix_t  mix
);

  `NWOM_ASSERT_NEXT(a_one_at_a_time, clk, rst, tick_valid && tick_ready, !tick_ready, "tick accepted while busy")
  `NWOM_ASSERT_NOW(a_busy_through_multiply, clk, rst, tick_valid && tick_ready, ##8 (!tick_ready), "ready returned too early")
  `NWOM_ASSERT_NEXT(a_stall_holds, clk, rst, mix_valid && !mix_ready, mix_valid && $stable(mix), "stalled word changed")
  `NWOM_ASSERT_NOW(a_word_after_work, clk, rst, $rose(mix_valid), $past(!tick_ready), "word appeared from idle")
  `NWOM_ASSERT_ALWAYS(a_reset_state, clk, rst, !mix_valid && tick_ready, "reset left block busy")

endmodule

bind note_waveform_oscillator_mixer_core nwom_port_chk u_port_chk (.*);
